// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check written as antecedent and consequent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	`ASSERT_CLKD(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/hsv2rgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// widths, reciprocal constants and sector codes of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// field widths
	localparam int HUE_W = 15;
	localparam int CH_W  = 8;

	// hue / (60 << frac) as (hue >> frac) / 60: whole degrees stay below 2^15
	localparam int DEG_W       = 15;
	localparam int REGION_W    = 10;
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 21;
	// ceil(2^21 / 60), exact for every 15-bit dividend
	localparam logic [RECIP_W-1:0] RECIP_60 = 16'd34953;

	// widths of the intermediate products
	localparam int PROD_W = 2 * CH_W;
	localparam int SR_W   = CH_W + HUE_W;

	localparam int NUM_SECT = 6;
	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	// hue sector, the last one also takes any hue of 360 degrees or more
	typedef enum logic [2:0] {
		SECT_RY = 3'd0,
		SECT_YG = 3'd1,
		SECT_GC = 3'd2,
		SECT_CB = 3'd3,
		SECT_BM = 3'd4,
		SECT_MR = 3'd5
	} sect_t;

endpackage

// ===== rtl/hsv_to_rgb_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// six-stage pipelined hsv to rgb colour conversion, one colour per clock
// ----------------------------------------------------------------------------
//
//  channel  | handshake     | payload
//  ---------+---------------+--------------------------------
//  input    | start / busy  | hue[14:0], saturation, value
//  output   | done          | red, green, blue
//
//  the accepting edge loads stage 1; done is the valid bit of stage 6
//  a new beat may enter in every cycle; busy never rises
//  the depth is set by the multiplier chain: sector, remainder, s*rem,
//  fractional term, q/t products, divide by 255 and mux
//  reset clears the valid bits only; payload registers are not reset
//  the receiver cannot stall, so done is a one-cycle strobe
//
module hsv_to_rgb_converter_unit #(
	parameter int HUE_FRAC_BITS = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [hsv2rgb_pkg::HUE_W-1:0] hue,
	input  logic [hsv2rgb_pkg::CH_W-1:0]  saturation,
	input  logic [hsv2rgb_pkg::CH_W-1:0]  value,
	output logic                         done,
	output logic [hsv2rgb_pkg::CH_W-1:0]  red,
	output logic [hsv2rgb_pkg::CH_W-1:0]  green,
	output logic [hsv2rgb_pkg::CH_W-1:0]  blue
);
	import hsv2rgb_pkg::*;

`include "assert_macros.svh"

	// hue units in one sector
	localparam logic [HUE_W-1:0] SEG = HUE_W'(60 << HUE_FRAC_BITS);

	// exact x / 255 for x up to 255 * 255
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] acc;
		acc = {1'b0, x} + {9'd0, x[PROD_W-1:CH_W]} + (PROD_W+1)'(1);
		return acc[PROD_W-1:CH_W];
	endfunction

	logic accept;
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 1: sector number by reciprocal multiply
	logic [DEG_W-1:0]               deg;
	logic [DEG_W+RECIP_W-1:0]       region_prod;
	logic [HUE_W-1:0]               hue_s1;
	logic [CH_W-1:0]                sat_s1, val_s1;
	logic [REGION_W-1:0]            region_s1;

	assign deg         = DEG_W'(hue >> HUE_FRAC_BITS);
	assign region_prod = {{RECIP_W{1'b0}}, deg} * {{DEG_W{1'b0}}, RECIP_60};

	always_ff @(posedge clk) begin
		hue_s1    <= hue;
		sat_s1    <= saturation;
		val_s1    <= value;
		region_s1 <= region_prod[RECIP_SHIFT +: REGION_W];
	end

	// stage 2: remainder in sector, sector clamp, p product
	logic [HUE_W-1:0]  seg_base;
	logic [CH_W-1:0]   inv_sat;
	logic [HUE_W-1:0]  rem_s2;
	sect_t             sect_d, sect_s2;
	logic [PROD_W-1:0] p_prod_s2;
	logic [CH_W-1:0]   sat_s2, val_s2;

	assign seg_base = HUE_W'(region_s1) * SEG;
	assign inv_sat  = CH_MAX - sat_s1;
	assign sect_d   = (region_s1 >= REGION_W'(NUM_SECT)) ? SECT_MR : sect_t'(region_s1[2:0]);

	always_ff @(posedge clk) begin
		rem_s2    <= hue_s1 - seg_base;
		sect_s2   <= sect_d;
		p_prod_s2 <= {{CH_W{1'b0}}, val_s1} * {{CH_W{1'b0}}, inv_sat};
		sat_s2    <= sat_s1;
		val_s2    <= val_s1;
	end

	// stage 3: saturation times remainder
	logic [SR_W-1:0]   sr_s3;
	sect_t             sect_s3;
	logic [PROD_W-1:0] p_prod_s3;
	logic [CH_W-1:0]   sat_s3, val_s3;

	always_ff @(posedge clk) begin
		sr_s3     <= {{HUE_W{1'b0}}, sat_s2} * {{CH_W{1'b0}}, rem_s2};
		sect_s3   <= sect_s2;
		p_prod_s3 <= p_prod_s2;
		sat_s3    <= sat_s2;
		val_s3    <= val_s2;
	end

	// stage 4: fractional term fs = s*rem / seg, again by reciprocal
	logic [SR_W-1:0]          sr_shift;
	logic [DEG_W+RECIP_W-1:0] fs_prod;
	logic [CH_W-1:0]          fs_s4;
	sect_t                    sect_s4;
	logic [PROD_W-1:0]        p_prod_s4;
	logic [CH_W-1:0]          sat_s4, val_s4;

	assign sr_shift = sr_s3 >> HUE_FRAC_BITS;
	assign fs_prod  = {{RECIP_W{1'b0}}, sr_shift[DEG_W-1:0]} * {{DEG_W{1'b0}}, RECIP_60};

	always_ff @(posedge clk) begin
		fs_s4     <= fs_prod[RECIP_SHIFT +: CH_W];
		sect_s4   <= sect_s3;
		p_prod_s4 <= p_prod_s3;
		sat_s4    <= sat_s3;
		val_s4    <= val_s3;
	end

	// stage 5: q and t products
	logic [CH_W-1:0]   q_fac, t_fac;
	logic [CH_W:0]     t_sum;
	logic [PROD_W-1:0] p_prod_s5, q_prod_s5, t_prod_s5;
	sect_t             sect_s5;
	logic [CH_W-1:0]   sat_s5, val_s5;

	assign q_fac = CH_MAX - fs_s4;
	// fs never exceeds s, so 255 - s + fs fits a channel
	assign t_sum = {1'b0, CH_MAX - sat_s4} + {1'b0, fs_s4};
	assign t_fac = t_sum[CH_W-1:0];

	always_ff @(posedge clk) begin
		q_prod_s5 <= {{CH_W{1'b0}}, val_s4} * {{CH_W{1'b0}}, q_fac};
		t_prod_s5 <= {{CH_W{1'b0}}, val_s4} * {{CH_W{1'b0}}, t_fac};
		p_prod_s5 <= p_prod_s4;
		sect_s5   <= sect_s4;
		sat_s5    <= sat_s4;
		val_s5    <= val_s4;
	end

	// stage 6: divide by 255 and sector mux
	// zero saturation needs no arm of its own: p, q and t all equal v then
	logic [CH_W-1:0] p_val, q_val, t_val;
	logic [CH_W-1:0] red_d, green_d, blue_d;
	logic [CH_W-1:0] red_s6, green_s6, blue_s6, val_s6, sat_s6;

	assign p_val = div255(p_prod_s5);
	assign q_val = div255(q_prod_s5);
	assign t_val = div255(t_prod_s5);

	always_comb begin
		unique case (sect_s5)
			SECT_RY: begin red_d = val_s5; green_d = t_val;  blue_d = p_val;  end
			SECT_YG: begin red_d = q_val;  green_d = val_s5; blue_d = p_val;  end
			SECT_GC: begin red_d = p_val;  green_d = val_s5; blue_d = t_val;  end
			SECT_CB: begin red_d = p_val;  green_d = q_val;  blue_d = val_s5; end
			SECT_BM: begin red_d = t_val;  green_d = p_val;  blue_d = val_s5; end
			default: begin red_d = val_s5; green_d = p_val;  blue_d = q_val;  end
		endcase
	end

	always_ff @(posedge clk) begin
		red_s6   <= red_d;
		green_s6 <= green_d;
		blue_s6  <= blue_d;
		val_s6   <= val_s5;
		sat_s6   <= sat_s5;
	end

	// output beat
	assign done  = valid_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// checks
	`ASSERT_IMPL(a_rem_in_sector, valid_s2, rem_s2 < SEG, "remainder outside sector")
	`ASSERT_IMPL(a_fs_below_sat, valid_s4 && sat_s4 != '0, fs_s4 < sat_s4, "fs not below saturation")
	`ASSERT_IMPL(a_p_smallest, valid_s5, p_prod_s5 <= q_prod_s5 && p_prod_s5 <= t_prod_s5, "p product not smallest")
	`ASSERT_IMPL(a_grey, done && sat_s6 == '0, red == val_s6 && green == val_s6 && blue == val_s6, "grey beat not grey")
	`ASSERT_IMPL(a_value_kept, done, red == val_s6 || green == val_s6 || blue == val_s6, "no channel carries value")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the hsv to rgb converter: directed corner colours,
// then constrained-by-hand random colours with random sender gaps; every
// accepted colour is predicted in the bench and every done strobe is checked
// against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

	import hsv2rgb_pkg::*;

	localparam int FRAC_BITS   = 6;
	localparam int SEG_UNITS   = 60 << FRAC_BITS;
	localparam int HUE_SPAN    = 6 * SEG_UNITS;
	localparam int RANDOM_BEATS = 1828;
	localparam int IDLE_PCT    = 9;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 10;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// expected colours in order, checked against each done strobe
	class rgb_scoreboard;
		rgb_t pending_rgb[$];
		int   mismatches;
		int   failures;

		function new();
			mismatches = 0;
			failures = 0;
		endfunction

		// hexcone conversion with truncating integer divisions
		function rgb_t convert_hsv(logic [HUE_W-1:0] h, logic [CH_W-1:0] s,
				logic [CH_W-1:0] v);
			int unsigned sector_idx, rem, fs, p, q, t;
			sect_t       sector;
			rgb_t        c;
			if (s == '0) begin
				c.red = v;
				c.green = v;
				c.blue = v;
				return c;
			end
			sector_idx = h / SEG_UNITS;
			rem = h % SEG_UNITS;
			fs = (s * rem) / SEG_UNITS;
			p = (v * (255 - s)) / 255;
			q = (v * (255 - fs)) / 255;
			t = (v * (255 - s + fs)) / 255;
			// hue of 360 degrees or more falls into the last sector
			sector = (sector_idx >= NUM_SECT) ? SECT_MR : sect_t'(sector_idx);
			case (sector)
				SECT_RY: c = '{v, t[CH_W-1:0], p[CH_W-1:0]};
				SECT_YG: c = '{q[CH_W-1:0], v, p[CH_W-1:0]};
				SECT_GC: c = '{p[CH_W-1:0], v, t[CH_W-1:0]};
				SECT_CB: c = '{p[CH_W-1:0], q[CH_W-1:0], v};
				SECT_BM: c = '{t[CH_W-1:0], p[CH_W-1:0], v};
				default: c = '{v, p[CH_W-1:0], q[CH_W-1:0]};
			endcase
			return c;
		endfunction

		function void note_colour(logic [HUE_W-1:0] h, logic [CH_W-1:0] s,
				logic [CH_W-1:0] v);
			pending_rgb.push_back(convert_hsv(h, s, v));
		endfunction

		function void check_colour(rgb_t got);
			rgb_t want;
			if (pending_rgb.size() == 0) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result r=%0d g=%0d b=%0d",
						$realtime, got.red, got.green, got.blue);
				return;
			end
			want = pending_rgb.pop_front();
			if (got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue) begin
				failures++;
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
						$realtime, want.red, want.green, want.blue,
						got.red, got.green, got.blue);
			end
		endfunction

		function int pending();
			return pending_rgb.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [HUE_W-1:0]  hue = '0;
	logic [CH_W-1:0]   saturation = '0;
	logic [CH_W-1:0]   value = '0;
	logic              done;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;

	rgb_scoreboard sb;
	int            stall_cycles = 0;

	hsv_to_rgb_converter_unit #(
		.HUE_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.value     (value),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// note accepted beats, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_colour(hue, saturation, value);
			if (done)
				sb.check_colour('{red, green, blue});
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// one beat, after a random gap
	task automatic send_colour(input logic [HUE_W-1:0] h, input logic [CH_W-1:0] s,
			input logic [CH_W-1:0] v, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hue mostly in range, with sector edges and out-of-range values
	function automatic logic [HUE_W-1:0] pick_hue();
		int sel;
		int edge_hue;
		sel = $urandom_range(99);
		if (sel < 65)
			return HUE_W'($urandom_range(HUE_SPAN - 1));
		if (sel < 80) begin
			edge_hue = $urandom_range(6) * SEG_UNITS + $urandom_range(4) - 2;
			if (edge_hue < 0)
				edge_hue = 0;
			return HUE_W'(edge_hue);
		end
		if (sel < 90)
			return HUE_W'($urandom_range((1 << HUE_W) - 1, HUE_SPAN));
		return HUE_W'($urandom);
	endfunction

	// channel value with extra weight on 0, 1, 254 and 255
	function automatic logic [CH_W-1:0] pick_channel();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8)
			return '0;
		if (sel < 16)
			return CH_MAX;
		if (sel < 20)
			return ($urandom_range(1) != 0) ? 8'd1 : 8'd254;
		return CH_W'($urandom);
	endfunction

	// stimulus
	initial begin
		int d_hue[] = '{0, 23039, 3839, 3840, 7680, 11520, 15360, 19200, 23040,
			32767, 16384, 5000, 0, 12345, 1919, 21000, 8191, 3841, 9600, 17000,
			26000, 4000};
		int d_sat[] = '{255, 255, 255, 255, 128, 200, 255, 77, 255, 255, 1, 0,
			0, 255, 255, 1, 170, 254, 255, 0, 100, 85};
		int d_val[] = '{255, 255, 255, 255, 200, 255, 128, 255, 255, 255, 255,
			137, 0, 0, 255, 1, 85, 254, 128, 255, 200, 170};
		int idle;

		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner colours
		foreach (d_hue[i])
			send_colour(HUE_W'(d_hue[i]), CH_W'(d_sat[i]), CH_W'(d_val[i]), IDLE_PCT);

		// random colours
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			// sender holds off until the pipeline has drained
			if (n == 900) begin
				start <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0)
					@(posedge clk);
			end
			// back-to-back stretch
			idle = (n >= 1200 && n < 1500) ? 0 : IDLE_PCT;
			send_colour(pick_hue(), pick_channel(), pick_channel(), idle);
		end
		start <= 1'b0;

		// drain
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
